### hw/rtl/ssdf_pkg.sv
// ----------------------------------------------------------------------------
// ssdf_pkg
// Shared types, field widths, operation codes and segment tables for the
// seven segment display formatter.
// ----------------------------------------------------------------------------
package ssdf_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned WID_W       = 3;
  localparam int unsigned VAL_W       = 14;
  localparam int unsigned WORD_W      = 11;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned PHYS_W      = 3;
  localparam int unsigned LOG_W       = 4;
  localparam int unsigned REMAP_SLOTS = 7;
  localparam int unsigned REMAP_W     = REMAP_SLOTS * PHYS_W;
  localparam int unsigned BCD_W       = 4;
  localparam int unsigned NUM_DIGS    = 4;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = REMAP_W;
  localparam int unsigned S_DATA_W    = 24;
  localparam int unsigned M_DATA_W    = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP = 1'b1;

  localparam logic [REMAP_W-1:0] REMAP_RESET = 21'd273182;

  typedef enum logic [OP_W-1:0] {
    OP_NUMBER  = 2'd0,
    OP_RAW     = 2'd1,
    OP_DOT_ON  = 2'd2,
    OP_DOT_OFF = 2'd3
  } op_e;

  // Fields of one item that travel unchanged alongside the digit split.
  typedef struct packed {
    op_e               op;
    logic [POS_W-1:0]  pos;
    logic [WID_W-1:0]  wid;     // clamped to 1..4
    logic [WORD_W-1:0] word;    // raw segment word, dot index in the low bits
    logic              dot_ok;  // dot index is 0..7
  } ctl_t;

  typedef struct packed {
    ctl_t                           ctl;
    logic [NUM_DIGS-1:0][BCD_W-1:0] digs;  // decimal digits, units at index 0
  } item_t;

  function automatic logic [WORD_W-1:0] seg_font(input logic [BCD_W-1:0] d);
    logic [WORD_W-1:0] w;
    case (d)
      4'd0:    w = 11'h578;
      4'd1:    w = 11'h500;
      4'd2:    w = 11'h670;
      4'd3:    w = 11'h750;
      4'd4:    w = 11'h708;
      4'd5:    w = 11'h358;
      4'd6:    w = 11'h378;
      4'd7:    w = 11'h510;
      4'd8:    w = 11'h778;
      4'd9:    w = 11'h758;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] dot_bit(input logic [2:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      3'd0:    w = 11'h010;
      3'd1:    w = 11'h400;
      3'd2:    w = 11'h100;
      3'd3:    w = 11'h040;
      3'd4:    w = 11'h020;
      3'd5:    w = 11'h008;
      3'd6:    w = 11'h200;
      default: w = 11'h080;
    endcase
    return w;
  endfunction

  // Physical digit of a logical position; positions past the table give 0
  // and are rejected by the caller.
  function automatic logic [PHYS_W-1:0] remap_phys(input logic [REMAP_W-1:0] remap,
                                                   input logic [LOG_W-1:0] lpos);
    logic [PHYS_W-1:0] res;
    res = '0;
    for (int k = 0; k < REMAP_SLOTS; k++) begin
      if (lpos == LOG_W'(k)) begin
        res = remap[PHYS_W*k +: PHYS_W];
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/ssdf_ram.sv
// ----------------------------------------------------------------------------
// ssdf_ram
// Generic single write port, single read port RAM with a registered read.
// A read of the address written in the same cycle returns the old word.
// ----------------------------------------------------------------------------
module ssdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hw/rtl/ssdf_digits.sv
// ----------------------------------------------------------------------------
// ssdf_digits
// Input pipeline: decodes the incoming transaction and splits the value into
// four decimal digits by reciprocal multiplication, at most two multiplies per stage.
// ----------------------------------------------------------------------------
module ssdf_digits
  import ssdf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [S_DATA_W-1:0] in_data_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output item_t               item_o
);

  logic              en;
  logic [5:0]        vld_q;

  ctl_t              ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  logic [VAL_W-1:0]  r1_q, r2_q;
  logic [BCD_W-1:0]  q3_q, d3a_q, d3b_q, d3c_q;
  logic [9:0]        r3a_q, r3b_q;
  logic [BCD_W-1:0]  q2_q, d2_q;
  logic [6:0]        r2x_q;
  item_t             item_q;

  logic [OP_W-1:0]   in_op;
  logic [POS_W-1:0]  in_pos;
  logic [WID_W-1:0]  in_wid;
  logic [VAL_W-1:0]  in_val;
  ctl_t              ctl_in;
  logic [VAL_W-1:0]  r_in;

  logic [24:0]       prod3;
  logic [VAL_W-1:0]  rem3;
  logic [19:0]       prod2;
  logic [9:0]        rem2;
  logic [14:0]       prod1;
  logic [BCD_W-1:0]  q1;
  logic [6:0]        d0;

  assign en           = !vld_q[5] || item_ready_i;
  assign in_ready_o   = en;
  assign item_valid_o = vld_q[5];
  assign item_o       = item_q;

  always_comb begin
    in_op  = in_data_i[1:0];
    in_pos = in_data_i[4:2];
    in_wid = in_data_i[7:5];
    in_val = in_data_i[21:8];

    ctl_in.op     = op_e'(in_op);
    ctl_in.pos    = in_pos;
    ctl_in.wid    = (in_wid == 3'd0) ? 3'd1 : ((in_wid > 3'd4) ? 3'd4 : in_wid);
    ctl_in.word   = in_val[WORD_W-1:0];
    ctl_in.dot_ok = (in_val[VAL_W-1:3] == '0);

    // Only the low four digits matter, so drop the ten-thousands.
    r_in = (in_val >= 14'd10000) ? (in_val - 14'd10000) : in_val;

    // Thousands: estimate never exceeds the true quotient by design. The
    // estimate is taken from stage one so that it lines up with r2_q.
    prod3 = 25'(r1_q) * 25'd1048;
    rem3  = r2_q - (14'(q3_q) * 14'd1000);

    // Hundreds.
    prod2 = 20'(r3a_q) * 20'd655;
    rem2  = r3b_q - (10'(q2_q) * 10'd100);

    // Tens and units; exact for values below one hundred.
    prod1 = 15'(r2x_q) * 15'd205;
    q1    = prod1[14:11];
    d0    = r2x_q - (7'(q1) * 7'd10);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl1_q <= ctl_in;
      r1_q   <= r_in;

      ctl2_q <= ctl1_q;
      r2_q   <= r1_q;
      q3_q   <= prod3[23:20];

      ctl3_q <= ctl2_q;
      if (rem3 >= 14'd1000) begin
        d3a_q <= q3_q + 4'd1;
        r3a_q <= 10'(rem3 - 14'd1000);
      end else begin
        d3a_q <= q3_q;
        r3a_q <= 10'(rem3);
      end

      ctl4_q <= ctl3_q;
      d3b_q  <= d3a_q;
      r3b_q  <= r3a_q;
      q2_q   <= prod2[19:16];

      ctl5_q <= ctl4_q;
      d3c_q  <= d3b_q;
      if (rem2 >= 10'd100) begin
        d2_q  <= q2_q + 4'd1;
        r2x_q <= 7'(rem2 - 10'd100);
      end else begin
        d2_q  <= q2_q;
        r2x_q <= 7'(rem2);
      end

      item_q.ctl  <= ctl5_q;
      item_q.digs <= {d3c_q, d2_q, q1, d0[BCD_W-1:0]};
    end
  end

endmodule

### hw/rtl/ssdf_seq.sv
// ----------------------------------------------------------------------------
// ssdf_seq
// Write sequencer: walks the digit slots of one item, keeps the shadow words
// in a RAM (read, modify, write back for dot updates) and holds the output.
// ----------------------------------------------------------------------------
module ssdf_seq
  import ssdf_pkg::*;
#(
  parameter int unsigned DIGITS = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  item_t               item_i,
  output logic                item_ready_o,
  input  logic                blz_i,
  input  logic [REMAP_W-1:0]  remap_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  localparam int unsigned AW       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [LOG_W-1:0] DIGITS_L = LOG_W'(DIGITS);

  // Issue stage.
  logic                                 iss_valid_q;
  item_t                                item_q;
  logic [SLOT_W-1:0]                    slot_q;
  logic                                 blank_q;

  logic [NUM_DIGS-1:0][PHYS_W-1:0]      slot_phys;
  logic [NUM_DIGS-1:0]                  slot_ok;
  logic [NUM_DIGS-1:0]                  lower_mask;
  logic [LOG_W-1:0]                     lpos;
  logic                                 in_map;
  logic                                 cur_ok;
  logic [PHYS_W-1:0]                    cur_phys;
  logic [BCD_W-1:0]                     cur_dig;
  logic                                 is_blank;
  logic                                 rmw;
  logic [WORD_W-1:0]                    cur_word;
  logic                                 cur_last;
  logic                                 step, done, take, send;

  // Write stage.
  logic                                 w_valid_q;
  logic [PHYS_W-1:0]                    w_phys_q;
  logic [WORD_W-1:0]                    w_word_q;
  logic                                 w_rmw_q;
  logic                                 w_set_q;
  logic [WORD_W-1:0]                    w_mask_q;
  logic                                 w_last_q;
  logic                                 w_fire, w_free;
  logic [WORD_W-1:0]                    w_base;
  logic [WORD_W-1:0]                    w_final;

  // Shadow bookkeeping.
  logic [DIGITS-1:0]                    written_q;
  logic                                 rd_written_q;
  logic                                 fwd_hit_q;
  logic [WORD_W-1:0]                    fwd_word_q;
  logic [WORD_W-1:0]                    rdata;

  // Output register.
  logic                                 out_valid_q;
  logic [ADDR_W-1:0]                    out_addr_q;
  logic [WORD_W-1:0]                    out_word_q;
  logic                                 out_last_q;
  logic                                 out_free;

  always_comb begin
    for (int j = 0; j < NUM_DIGS; j++) begin
      lpos         = LOG_W'(item_q.ctl.pos) + LOG_W'(j);
      slot_phys[j] = remap_phys(remap_i, lpos);
      in_map       = (lpos < LOG_W'(REMAP_SLOTS)) && (lpos < DIGITS_L) &&
                     ({1'b0, slot_phys[j]} < DIGITS_L);
      if (item_q.ctl.op == OP_NUMBER) begin
        slot_ok[j] = in_map && (WID_W'(j) < item_q.ctl.wid);
      end else begin
        slot_ok[j] = (j == 0) && in_map &&
                     ((item_q.ctl.op == OP_RAW) || item_q.ctl.dot_ok);
      end
    end

    lower_mask = (NUM_DIGS'(1) << slot_q) - NUM_DIGS'(1);
    cur_ok     = slot_ok[slot_q];
    cur_phys   = slot_phys[slot_q];
    cur_dig    = item_q.digs[slot_q];
    cur_last   = ((slot_ok & lower_mask) == '0);
    is_blank   = (slot_q != '0) && blank_q && (cur_dig == '0);
    rmw        = (item_q.ctl.op == OP_DOT_ON) || (item_q.ctl.op == OP_DOT_OFF);

    case (item_q.ctl.op)
      OP_NUMBER: cur_word = is_blank ? '0 : seg_font(cur_dig);
      OP_RAW:    cur_word = item_q.ctl.word;
      default:   cur_word = '0;
    endcase

    out_free = !out_valid_q || m_axis_tready;
    w_fire   = w_valid_q && out_free;
    w_free   = !w_valid_q || w_fire;

    step = iss_valid_q && (!cur_ok || w_free);
    done = step && (slot_q == '0);
    send = step && cur_ok;
    take = !iss_valid_q || done;

    // Newest value of the entry: a write that went in while the read was
    // issued wins over the RAM, and an entry never written reads as blank.
    if (fwd_hit_q) begin
      w_base = fwd_word_q;
    end else if (rd_written_q) begin
      w_base = rdata;
    end else begin
      w_base = '0;
    end

    if (!w_rmw_q) begin
      w_final = w_word_q;
    end else if (w_set_q) begin
      w_final = w_base | w_mask_q;
    end else begin
      w_final = w_base & ~w_mask_q;
    end
  end

  assign item_ready_o  = take;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_word_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

  ssdf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DIGITS)
  ) u_shadow (
    .clk_i   (clk_i),
    .we_i    (w_fire),
    .waddr_i (w_phys_q[AW-1:0]),
    .wdata_i (w_final),
    .re_i    (send),
    .raddr_i (cur_phys[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_valid_q <= 1'b0;
      w_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      written_q   <= '0;
    end else begin
      if (take) begin
        iss_valid_q <= item_valid_i;
      end
      if (send) begin
        w_valid_q <= 1'b1;
      end else if (w_fire) begin
        w_valid_q <= 1'b0;
      end
      if (w_fire) begin
        out_valid_q                  <= 1'b1;
        written_q[w_phys_q[AW-1:0]]  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q  <= item_i;
      slot_q  <= (item_i.ctl.op == OP_NUMBER) ? SLOT_W'(item_i.ctl.wid - 3'd1) : '0;
      blank_q <= (item_i.ctl.wid >= 3'd3) && blz_i;
    end else if (step) begin
      slot_q  <= slot_q - SLOT_W'(1);
      blank_q <= is_blank;
    end

    if (send) begin
      w_phys_q     <= cur_phys;
      w_word_q     <= cur_word;
      w_rmw_q      <= rmw;
      w_set_q      <= (item_q.ctl.op == OP_DOT_ON);
      w_mask_q     <= dot_bit(item_q.ctl.word[2:0]);
      w_last_q     <= cur_last;
      fwd_hit_q    <= w_fire && (w_phys_q == cur_phys);
      fwd_word_q   <= w_final;
      rd_written_q <= written_q[cur_phys[AW-1:0]];
    end

    if (w_fire) begin
      out_addr_q <= {w_phys_q, 1'b0};
      out_word_q <= w_final;
      out_last_q <= w_last_q;
    end
  end

endmodule

### hw/rtl/seven_segment_display_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_display_formatter
// Turns display commands into display RAM writes for a multi-digit LED panel.
// ----------------------------------------------------------------------------
// Each input transaction carries one command: show a decimal number of one to
// four digits, write a raw segment word, or set or clear one dot segment. Every
// digit that is written leaves as one output transaction with the display RAM
// address (physical digit times two) and the segment word, and tlast marks the
// final write of a command. Numbers are written most significant digit first,
// are reduced modulo ten to the width, and, when leading zero blanking is on,
// three and four digit numbers show blanks instead of leading zeros (the units
// digit always shows). Logical positions pass through the remap register to
// physical digits; writes that land past the last logical or physical digit are
// dropped, and a command whose writes are all dropped produces no output. A
// copy of every digit's word is kept in a small RAM so that dot commands can
// read, modify and write back the current word; the copy reads as blank after
// reset. A number command holds the write sequencer for all its digit slots,
// every other command for its single slot. A new transaction is accepted in
// the cycle in which the previous one leaves the sequencer, so a stream of
// one-digit commands runs at one per cycle while the output takes each write.
// A command passes the digit split pipeline, the sequencer's issue stage, the
// write stage and the output register. Configuration must be written only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module seven_segment_display_formatter
  import ssdf_pkg::*;
#(
  parameter int unsigned DIGITS = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input command stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: op[1:0], position[4:2], width[7:5], value[21:8].
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // Display write stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: ram_address[3:0], segment_word[14:4].
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  output logic                  m_axis_tlast,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic               blz_q;
  logic [REMAP_W-1:0] remap_q;

  // Hand-off from the digit split to the sequencer.
  logic  item_valid;
  logic  item_ready;
  item_t item;

  // Register writes take effect at once. The user must make them only while idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blz_q   <= 1'b0;
      remap_q <= REMAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLANK: blz_q   <= cfg_data_i[0];
        CFG_REMAP: remap_q <= cfg_data_i[REMAP_W-1:0];
        default:   ;
      endcase
    end
  end

  // Decode and split the number into decimal digits.
  ssdf_digits u_digits (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // Walk the digit slots, update the shadow words and drive the writes.
  ssdf_seq #(
    .DIGITS (DIGITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_ready_o  (item_ready),
    .blz_i         (blz_q),
    .remap_i       (remap_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
